### rtl/coagulation_kernel_eval_defines.svh
// ----------------------------------------------------------------
// Coagulation kernel evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------
`ifndef COAGULATION_KERNEL_EVAL_DEFINES_SVH
`define COAGULATION_KERNEL_EVAL_DEFINES_SVH

// plain property
`define CKE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication
`define CKE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/cke_pkg.sv
// ----------------------------------------------------------------
// Coagulation kernel evaluator package
// Request/response types, kernel codes and unit depths.
// ----------------------------------------------------------------
package cke_pkg;

  localparam int unsigned RAD_W      = 64;  // radicand / dividend width
  localparam int unsigned CBRT_W     = 22;  // floor cube root of a 64-bit value
  localparam int unsigned SQRT_W     = 32;  // floor square root of a 64-bit value
  localparam int unsigned DIV_W      = 34;  // divisor and quotient width
  localparam int unsigned CBRT_STEPS = (RAD_W + 2) / 3;
  localparam int unsigned SQRT_STEPS = RAD_W / 2;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned MODE_W     = 4;

  typedef enum logic [MODE_W-1:0] {
    KM_CONTINUUM    = 4'd0,
    KM_FREE_MOL     = 4'd1,
    KM_KINETIC      = 4'd2,
    KM_LIN_SHEAR    = 4'd3,
    KM_NONLIN_SHEAR = 4'd4,
    KM_SETTLING     = 4'd5,
    KM_INERTIAL     = 4'd6,
    KM_BERRY        = 4'd7,
    KM_CONDENSE     = 4'd8,
    KM_ADDITIVE     = 4'd9,
    KM_MULT         = 4'd10,
    KM_CBRT_TEST    = 4'd11,
    KM_CONSTANT     = 4'd12
  } kernel_mode_e;

  typedef struct packed {
    logic [31:0] size_a;
    logic [31:0] size_b;
  } cke_req_t;

  typedef struct packed {
    logic [55:0] kernel_value;
    logic        saturated;
  } cke_rsp_t;

endpackage

### rtl/cke_cbrt.sv
// ----------------------------------------------------------------
// cke_cbrt
// Pipelined floor cube root, one result bit per stage.
// ----------------------------------------------------------------
module cke_cbrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cke_pkg::RAD_W-1:0]   rad_i,
  output logic [cke_pkg::CBRT_W-1:0]  root_o
);
  import cke_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]    rem;
    logic [CBRT_W-1:0]   root;
    logic [2*CBRT_W-1:0] sq;    // root squared, kept to avoid a multiplier
  } cbrt_st_t;

  // (2r+1)^3 - (2r)^3 = 3*(4r^2 + 2r) + 1
  function automatic cbrt_st_t cbrt_step(cbrt_st_t st, int unsigned sh);
    cbrt_st_t            nx;
    logic [CBRT_W-1:0]   r2;
    logic [2*CBRT_W-1:0] s2;
    logic [RAD_W-1:0]    b;
    r2 = st.root << 1;
    s2 = st.sq << 2;
    b  = RAD_W'(s2) + RAD_W'(r2);
    b  = (b << 1) + b + RAD_W'(1);
    nx.rem  = st.rem;
    nx.root = r2;
    nx.sq   = s2;
    if ((st.rem >> sh) >= b) begin
      nx.rem  = st.rem - (b << sh);
      nx.root = r2 | CBRT_W'(1);
      nx.sq   = s2 + (2*CBRT_W)'({r2, 1'b0}) + (2*CBRT_W)'(1);
    end
    return nx;
  endfunction

  cbrt_st_t init;
  cbrt_st_t st_q [CBRT_STEPS];

  always_comb begin
    init.rem  = rad_i;
    init.root = '0;
    init.sq   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= cbrt_step(init, 3 * (CBRT_STEPS - 1));
    end
  end

  for (genvar j = 1; j < CBRT_STEPS; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= cbrt_step(st_q[j-1], 3 * (CBRT_STEPS - 1 - j));
      end
    end
  end

  assign root_o = st_q[CBRT_STEPS-1].root;

endmodule

### rtl/cke_isqrt.sv
// ----------------------------------------------------------------
// cke_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------
module cke_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cke_pkg::RAD_W-1:0]   rad_i,
  output logic [cke_pkg::SQRT_W-1:0]  root_o
);
  import cke_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [SQRT_W-1:0] root;
  } sqrt_st_t;

  // (2r+1)^2 - (2r)^2 = 4r + 1
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, int unsigned sh);
    sqrt_st_t         nx;
    logic [RAD_W-1:0] b;
    b = RAD_W'({st.root, 2'b01});
    nx.rem  = st.rem;
    nx.root = st.root << 1;
    if ((st.rem >> sh) >= b) begin
      nx.rem  = st.rem - (b << sh);
      nx.root = (st.root << 1) | SQRT_W'(1);
    end
    return nx;
  endfunction

  sqrt_st_t init;
  sqrt_st_t st_q [SQRT_STEPS];

  always_comb begin
    init.rem  = rad_i;
    init.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sqrt_step(init, 2 * (SQRT_STEPS - 1));
    end
  end

  for (genvar j = 1; j < SQRT_STEPS; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= sqrt_step(st_q[j-1], 2 * (SQRT_STEPS - 1 - j));
      end
    end
  end

  assign root_o = st_q[SQRT_STEPS-1].root;

endmodule

### rtl/cke_div.sv
// ----------------------------------------------------------------
// cke_div
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit DIV_W bits.
// ----------------------------------------------------------------
module cke_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cke_pkg::RAD_W-1:0]  num_i,
  input  logic [cke_pkg::DIV_W-1:0]  den_i,
  output logic [cke_pkg::DIV_W-1:0]  quo_o
);
  import cke_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [DIV_W-1:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t st, int unsigned pos);
    div_st_t nx;
    nx = st;
    if ((st.rem >> pos) >= RAD_W'(st.den)) begin
      nx.rem = st.rem - (RAD_W'(st.den) << pos);
      nx.quo = st.quo | (DIV_W'(1) << pos);
    end
    return nx;
  endfunction

  div_st_t init;
  div_st_t st_q [DIV_STEPS];

  always_comb begin
    init.rem = num_i;
    init.den = den_i;
    init.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(init, DIV_STEPS - 1);
    end
  end

  for (genvar j = 1; j < DIV_STEPS; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= div_step(st_q[j-1], DIV_STEPS - 1 - j);
      end
    end
  end

  assign quo_o = st_q[DIV_STEPS-1].quo;

endmodule

### rtl/coagulation_kernel_eval.sv
// ----------------------------------------------------------------
// Coagulation kernel evaluator
// Pipelined Smoluchowski kernel: size pair in, Q40.16 rate out.
// ----------------------------------------------------------------
// Usage
//   Request channel: in_valid_i / in_ready_o with in_req_i (two Q16.16
//   sizes, a raw zero is taken as the least positive code).
//   Response channel: out_valid_o / out_ready_i with out_rsp_o (Q40.16
//   rate plus a saturation flag, value clamped to all ones).
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_data_i, the kernel
//   code; always ready. Write it only while no request is in flight.
//   Each request latches the kernel code in force when it is accepted.
// Timing
//   One request per cycle while out_ready_i does not stall the pipe. The
//   response register loads at the end of the pipeline, whose depth is
//   set by the kinetic kernel's chain: square root, divide, multiply, divide.
//   All kernels share that single fixed-latency pipeline.
// Reset
//   Clears all valid bits and the response valid; kernel code = constant.
// Backpressure
//   When a response is held and out_ready_i is low the whole pipeline
//   freezes and in_ready_o drops; nothing is lost or duplicated.
// ----------------------------------------------------------------
`include "coagulation_kernel_eval_defines.svh"

module coagulation_kernel_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cke_pkg::cke_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cke_pkg::cke_rsp_t             out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cke_pkg::MODE_W-1:0]    cfg_data_i
);
  import cke_pkg::*;

  // stage numbers, counted from the input register (stage 0)
  localparam int unsigned K_MUL  = 1;                       // sum, products
  localparam int unsigned K_RES0 = K_MUL + 1;               // result line start
  localparam int unsigned K_CR   = CBRT_STEPS;              // cube roots of sizes
  localparam int unsigned K_T    = K_CR + 1;                // t = ca + cb
  localparam int unsigned K_TT   = K_T + 1;                 // t^2
  localparam int unsigned K_SQ   = K_MUL + SQRT_STEPS;      // sqrt(ab), sqrt(s)
  localparam int unsigned K_BRY  = K_MUL + DIV_STEPS;       // Berry quotient
  localparam int unsigned K_CT   = K_T + CBRT_STEPS;        // cube root of t
  localparam int unsigned K_INV  = K_CR + DIV_STEPS;        // inverse cube roots
  localparam int unsigned K_SUM  = K_INV + 1;               // ia + ib
  localparam int unsigned K_SQ1  = K_SUM + SQRT_STEPS;      // sqrt(ia + ib)
  localparam int unsigned K_Q    = K_SQ + DIV_STEPS;        // kinetic q
  localparam int unsigned K_TQ   = K_Q + 1;                 // t * q
  localparam int unsigned K_KIN  = K_TQ + DIV_STEPS;        // kinetic result

  localparam logic [63:0] OUT_MAX = (64'd1 << 56) - 64'd1;
  localparam logic [63:0] ONE_Q16 = 64'd1 << 16;

  // ---- control -------------------------------------------------
  logic             adv;            // whole pipe moves this cycle
  logic [MODE_W-1:0] kernel_mode_q;
  logic             v_q    [0:K_KIN];
  logic [MODE_W-1:0] mode_q [0:K_KIN];
  logic             out_valid_q;
  cke_rsp_t         out_rsp_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_mode_q <= KM_CONSTANT;
    end else if (cfg_valid_i) begin
      kernel_mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= K_KIN; k++) v_q[k] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k <= K_KIN; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode_q[0] <= kernel_mode_q;
      for (int k = 1; k <= K_KIN; k++) mode_q[k] <= mode_q[k-1];
    end
  end

  // ---- stage 0: sizes, zero mapped to one ---------------------
  logic [31:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= (in_req_i.size_a == '0) ? 32'd1 : in_req_i.size_a;
      b_q <= (in_req_i.size_b == '0) ? 32'd1 : in_req_i.size_b;
    end
  end

  // ---- stage 1: s = a+b, a*b, (a-b)^2 --------------------------
  logic [31:0] d_w;
  logic [63:0] ab_q, dd_q;
  logic [32:0] s_q [K_MUL:K_SQ];

  assign d_w = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[K_MUL] <= 33'(a_q) + 33'(b_q);
      ab_q       <= 64'(a_q) * 64'(b_q);
      dd_q       <= 64'(d_w) * 64'(d_w);
      for (int k = K_MUL + 1; k <= K_SQ; k++) s_q[k] <= s_q[k-1];
    end
  end

  // ---- arithmetic units -----------------------------------------
  logic [CBRT_W-1:0] ca_w, cb_w, ct_w;
  logic [SQRT_W-1:0] sab_w, r_w, sq1_w;
  logic [DIV_W-1:0]  bry_w, ia_w, ib_w, q_w, kin_w;

  logic [22:0] t_q  [K_T:K_Q];
  logic [29:0] tt_q [K_TT:K_SQ1];
  logic [24:0] r_q  [K_SQ+1:K_TQ];
  logic [22:0] sum_q;
  logic [39:0] tq_q;

  cke_cbrt u_cbrt_a (.clk_i, .en_i(adv), .rad_i({a_q, 32'd0}), .root_o(ca_w));
  cke_cbrt u_cbrt_b (.clk_i, .en_i(adv), .rad_i({b_q, 32'd0}), .root_o(cb_w));
  cke_cbrt u_cbrt_t (.clk_i, .en_i(adv), .rad_i({9'd0, t_q[K_T], 32'd0}), .root_o(ct_w));

  cke_isqrt u_sqrt_ab  (.clk_i, .en_i(adv), .rad_i(ab_q), .root_o(sab_w));
  cke_isqrt u_sqrt_s   (.clk_i, .en_i(adv), .rad_i({15'd0, s_q[K_MUL], 16'd0}),
                        .root_o(r_w));
  cke_isqrt u_sqrt_inv (.clk_i, .en_i(adv), .rad_i({25'd0, sum_q, 16'd0}),
                        .root_o(sq1_w));

  cke_div u_div_bry (.clk_i, .en_i(adv), .num_i(dd_q),
                     .den_i(DIV_W'(s_q[K_MUL])), .quo_o(bry_w));
  cke_div u_div_ia  (.clk_i, .en_i(adv), .num_i(64'd1 << 32),
                     .den_i(DIV_W'(ca_w)), .quo_o(ia_w));
  cke_div u_div_ib  (.clk_i, .en_i(adv), .num_i(64'd1 << 32),
                     .den_i(DIV_W'(cb_w)), .quo_o(ib_w));
  cke_div u_div_q   (.clk_i, .en_i(adv), .num_i({16'd0, sab_w, 16'd0}),
                     .den_i(DIV_W'(s_q[K_SQ])), .quo_o(q_w));
  cke_div u_div_kin (.clk_i, .en_i(adv), .num_i(64'(tq_q)),
                     .den_i(DIV_W'(r_q[K_TQ])), .quo_o(kin_w));

  // ---- cube-root side: t, t^2, differences ----------------------
  logic [21:0] ca_q, cb_q, ad5_q;
  logic [27:0] sqa_q, sqb_q, c11_q, ad6_q;
  logic [43:0] caa_w, cbb_w, cab_w;
  logic [45:0] ttp_w;

  assign caa_w = 44'(ca_w) * 44'(ca_w);
  assign cbb_w = 44'(cb_w) * 44'(cb_w);
  assign cab_w = 44'(ca_w) * 44'(cb_w);
  assign ttp_w = 46'(t_q[K_T]) * 46'(t_q[K_T]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ca_q       <= ca_w;
      cb_q       <= cb_w;
      t_q[K_T]   <= 23'(ca_w) + 23'(cb_w);
      sqa_q      <= caa_w[43:16];
      sqb_q      <= cbb_w[43:16];
      c11_q      <= cab_w[43:16];
      tt_q[K_TT] <= ttp_w[45:16];
      ad5_q      <= (ca_q > cb_q) ? (ca_q - cb_q) : (cb_q - ca_q);
      ad6_q      <= (sqa_q > sqb_q) ? (sqa_q - sqb_q) : (sqb_q - sqa_q);
      for (int k = K_T + 1; k <= K_Q; k++) t_q[k] <= t_q[k-1];
      for (int k = K_TT + 1; k <= K_SQ1; k++) tt_q[k] <= tt_q[k-1];
      // inverse cube roots fit 22 bits, sum fits 23
      sum_q      <= 23'(ia_w[21:0]) + 23'(ib_w[21:0]);
    end
  end

  // ---- kinetic side ---------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[K_SQ+1] <= r_w[24:0];
      for (int k = K_SQ + 2; k <= K_TQ; k++) r_q[k] <= r_q[k-1];
      // q never exceeds 2^15 since sqrt(ab) <= (a+b)/2
      tq_q      <= 40'(t_q[K_Q]) * 40'(q_w[16:0]);
    end
  end

  // ---- result line ------------------------------------------------
  // Each kernel's value, but the kinetic one taken at the output, is dropped
  // into the line at the stage where it is ready; later stages just carry it.
  logic [52:0] m3_p;
  logic [51:0] m5_p;
  logic [57:0] m6_p;
  logic [48:0] m4_p;
  logic [45:0] m0_p;
  logic [49:0] m1_p;
  logic [63:0] res_d [K_RES0:K_KIN];
  logic [63:0] res_q [K_RES0:K_KIN];
  logic [63:0] fin_w;

  assign m3_p = 53'(tt_q[K_TT]) * 53'(t_q[K_TT]);
  assign m5_p = 52'(tt_q[K_TT]) * 52'(ad5_q);
  assign m6_p = 58'(tt_q[K_TT]) * 58'(ad6_q);
  assign m4_p = 49'(tt_q[K_CT]) * 49'(ct_w[18:0]);
  assign m0_p = 46'(t_q[K_SUM]) * 46'(sum_q);
  assign m1_p = 50'(tt_q[K_SQ1]) * 50'(sq1_w[19:0]);

  always_comb begin
    case (mode_q[K_MUL])
      KM_CONDENSE: res_d[K_RES0] = 64'(ab_q[63:16]) + 64'({s_q[K_MUL], 1'b0})
                                   + (64'd1 << 18);
      KM_ADDITIVE: res_d[K_RES0] = 64'(s_q[K_MUL]);
      KM_MULT:     res_d[K_RES0] = 64'(ab_q[63:17]);
      default:     res_d[K_RES0] = ONE_Q16;
    endcase
    for (int k = K_RES0 + 1; k <= K_KIN; k++) res_d[k] = res_q[k-1];

    if (mode_q[K_T] == KM_CBRT_TEST) res_d[K_TT] = 64'(c11_q);

    case (mode_q[K_TT])
      KM_LIN_SHEAR: res_d[K_TT+1] = 64'(m3_p[52:16]);
      KM_SETTLING:  res_d[K_TT+1] = 64'(m5_p[51:16]);
      KM_INERTIAL:  res_d[K_TT+1] = 64'(m6_p[57:16]);
      default:      res_d[K_TT+1] = res_q[K_TT];
    endcase

    if (mode_q[K_BRY] == KM_BERRY)        res_d[K_BRY+1] = 64'(bry_w);
    if (mode_q[K_CT] == KM_NONLIN_SHEAR)  res_d[K_CT+1]  = 64'(m4_p[48:16]);
    if (mode_q[K_SUM] == KM_CONTINUUM)    res_d[K_SUM+1] = 64'(m0_p[45:16]);
    if (mode_q[K_SQ1] == KM_FREE_MOL)     res_d[K_SQ1+1] = 64'(m1_p[49:16]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = K_RES0; k <= K_KIN; k++) res_q[k] <= res_d[k];
    end
  end

  // ---- output register with clamp -------------------------------
  assign fin_w = (mode_q[K_KIN] == KM_KINETIC) ? 64'(kin_w) : res_q[K_KIN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[K_KIN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q.saturated    <= (fin_w > OUT_MAX);
      out_rsp_q.kernel_value <= (fin_w > OUT_MAX) ? '1 : fin_w[55:0];
    end
  end

  // ---- assertions -------------------------------------------------
  `CKE_ASSERT_IMP(a_out_from_pipe, $rose(out_valid_o), $past(v_q[K_KIN]), "response without request")
  `CKE_ASSERT_IMP(a_sat_clamped, out_valid_o && out_rsp_o.saturated, &out_rsp_o.kernel_value, "saturated value not clamped")
  `CKE_ASSERT_IMP(a_stall_holds, !$past(adv), $stable(out_rsp_q) && $stable(res_q[K_KIN]), "pipeline moved during stall")
  `CKE_ASSERT_IMP(a_kin_q_bound, v_q[K_Q] && mode_q[K_Q] == KM_KINETIC, q_w[DIV_W-1:16] == '0, "kinetic quotient out of range")
  `CKE_ASSERT_IMP(a_cbrt_nonzero, v_q[K_CR], ca_w != '0 && cb_w != '0, "zero cube root reached divider")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// Coagulation kernel evaluator testbench
// Streams size pairs through every kernel code, predicts each rate in
// integer arithmetic and compares responses in order, under random gaps
// on the request side and random stalls on the response side.
// ----------------------------------------------------------------
module testbench;
  import cke_pkg::*;

  localparam int unsigned LATENCY = 103;
  localparam logic [55:0] RATE_MAX = {56{1'b1}};

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  cke_req_t   in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  cke_rsp_t   out_rsp_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [MODE_W-1:0] cfg_data_i;

  coagulation_kernel_eval i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // pending requests, the mode each was issued under, and expected rates
  cke_req_t          req_q[$];
  logic [MODE_W-1:0] req_mode_q[$];
  cke_rsp_t          rate_q[$];
  logic [MODE_W-1:0] kernel_sel;   // predictor copy of the mode register
  int                n_err = 0;
  int                n_rsp = 0;
  int                n_req = 0;
  int                in_gap;
  int                out_stall;
  bit                drive_en;     // driver runs only outside config phases

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] cube_root(logic [63:0] n);
    logic [63:0] lo, hi, m;
    lo = 0;
    hi = 64'd2642245;
    while (lo < hi) begin
      m = lo + (hi - lo + 1) / 2;
      if (m * m * m <= n) lo = m; else hi = m - 1;
    end
    return lo;
  endfunction

  function automatic logic [63:0] square_root(logic [63:0] n);
    logic [63:0] lo, hi, m;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      m = lo + (hi - lo + 1) / 2;
      if (m * m <= n) lo = m; else hi = m - 1;
    end
    return lo;
  endfunction

  function automatic logic [63:0] q16_mul(logic [63:0] p, logic [63:0] q);
    logic [63:0] pr;
    pr = p * q;   // wraps at 64 bits like the integer model
    return pr >> 16;
  endfunction

  function automatic logic [63:0] abs_diff(logic [63:0] p, logic [63:0] q);
    return (p > q) ? p - q : q - p;
  endfunction

  function automatic cke_rsp_t kernel_rate(cke_req_t r, logic [MODE_W-1:0] mode);
    logic [63:0] a, b, ca, cb, ia, ib, t, s, v, q, d, sq;
    cke_rsp_t rsp;
    a = {32'd0, r.size_a};
    b = {32'd0, r.size_b};
    if (a == 0) a = 1;   // raw zero reads as least positive size
    if (b == 0) b = 1;
    ca = cube_root(a << 32);
    cb = cube_root(b << 32);
    ia = (64'd1 << 32) / ca;
    ib = (64'd1 << 32) / cb;
    t = ca + cb;
    s = a + b;
    case (mode)
      KM_CONTINUUM:    v = q16_mul(t, ia + ib);
      KM_FREE_MOL:     v = q16_mul(q16_mul(t, t), square_root((ia + ib) << 16));
      KM_KINETIC: begin
        q  = (square_root(a * b) << 16) / s;
        sq = square_root(s << 16);
        v  = (t * q) / sq;
      end
      KM_LIN_SHEAR:    v = q16_mul(q16_mul(t, t), t);
      KM_NONLIN_SHEAR: v = q16_mul(q16_mul(t, t), cube_root(t << 32));
      KM_SETTLING:     v = q16_mul(q16_mul(t, t), abs_diff(ca, cb));
      KM_INERTIAL:
        v = q16_mul(q16_mul(t, t), abs_diff(q16_mul(ca, ca), q16_mul(cb, cb)));
      KM_BERRY: begin
        d = abs_diff(a, b);
        v = (d * d) / s;
      end
      KM_CONDENSE:     v = ((a * b) >> 16) + 2 * s + (64'd1 << 18);
      KM_ADDITIVE:     v = s;
      KM_MULT:         v = (a * b) >> 17;
      KM_CBRT_TEST:    v = q16_mul(ca, cb);
      default:         v = 64'd1 << 16;   // constant, and unused codes
    endcase
    if (v > {8'd0, RATE_MAX}) begin
      rsp.kernel_value = RATE_MAX;
      rsp.saturated    = 1'b1;
    end else begin
      rsp.kernel_value = v[55:0];
      rsp.saturated    = 1'b0;
    end
    return rsp;
  endfunction

  // short gaps mostly, a few long ones, and stretches with none
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------- driver ----------------
  // The mode travels with each request so the predictor uses the code that
  // was in force at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rate_q.push_back(kernel_rate(in_req_i, req_mode_q.pop_front()));
        n_req <= n_req + 1;
        void'(req_q.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the request until accepted
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (drive_en && req_q.size() > 0) begin
        // an accepted head was popped above, so the next one is at the front
        in_valid_i <= 1'b1;
        in_req_i   <= req_q[0];
        in_gap     <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    cke_rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_rsp <= n_rsp + 1;
        if (rate_q.size() == 0) begin
          $display("%0t: unexpected response %h/%b", $time,
                   out_rsp_o.kernel_value, out_rsp_o.saturated);
          n_err = n_err + 1;
        end else begin
          exp_rsp = rate_q.pop_front();
          if (out_rsp_o.kernel_value !== exp_rsp.kernel_value) begin
            $display("%0t: kernel_value expected %h actual %h", $time,
                     exp_rsp.kernel_value, out_rsp_o.kernel_value);
            n_err = n_err + 1;
          end
          if (out_rsp_o.saturated !== exp_rsp.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_rsp.saturated, out_rsp_o.saturated);
            n_err = n_err + 1;
          end
        end
      end
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall   <= out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_stall   <= pick_gap();
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rand_size();
    logic [31:0] v;
    int k;
    k = $urandom_range(0, 9);
    if (k < 4)      v = $urandom();                            // full range
    else if (k < 7) v = $urandom_range(32'h8000, 32'h40000);   // near one
    else if (k < 9) v = $urandom() >> $urandom_range(0, 31);   // all magnitudes
    else            v = $urandom_range(0, 3);                  // tiny, zero too
    return v;
  endfunction

  task automatic queue_req(logic [31:0] a, logic [31:0] b);
    cke_req_t r;
    r.size_a = a;
    r.size_b = b;
    req_q.push_back(r);
    req_mode_q.push_back(kernel_sel);
  endtask

  // drain all expected responses, then let the pipeline settle
  task automatic drain();
    drive_en = 1'b1;
    wait (req_q.size() == 0 && rate_q.size() == 0);
    drive_en = 1'b0;
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kernel_sel = m;
  endtask

  initial begin
    int m, i;
    drive_en = 1'b0;
    kernel_sel = KM_CONSTANT;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset mode is the constant kernel
    queue_req(32'h1_0000, 32'h2_0000);
    queue_req(32'd0, 32'hFFFF_FFFF);
    drain();
    // directed: field extremes through every code, unused codes included
    for (m = 0; m < 16; m++) begin
      write_mode(m[MODE_W-1:0]);
      queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(32'd1, 32'hFFFF_FFFF);
      queue_req(32'd0, 32'd0);
      queue_req(32'h1_0000, 32'h1_0000);
      queue_req(32'hAAAA_5555, 32'h5555_AAAA);
      drain();
    end
    // random phases over random modes, extremes 0 and 12 included
    for (i = 0; i < 29; i++) begin
      if (i == 0)      write_mode(KM_CONTINUUM);
      else if (i == 1) write_mode(KM_CONSTANT);
      else if (i == 2) write_mode(4'd15);
      else             write_mode(MODE_W'($urandom_range(0, 15)));
      repeat (47) queue_req(rand_size(), rand_size());
      drain();
    end
    $display("Covered %0d requests and %0d responses over all 16 kernel codes.",
             n_req, n_rsp);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
